// ----- rtl/ctd_pkg.sv -----
// Shared types and constants for the CTAPHID report deframer.
`default_nettype none
package ctd_pkg;

  // Default report size in bytes
  localparam int REPORT_BYTES_DEF = 64;

  // Header byte positions
  localparam int CHAN_LAST_POS  = 3;
  localparam int CMD_POS        = 4;
  localparam int LEN_HI_POS     = 5;
  localparam int LEN_LO_POS     = 6;
  localparam int NONCE_LAST_POS = 14;

  // Command bytes and header masks
  localparam logic [7:0] CMD_FLAG = 8'h80;
  localparam logic [6:0] SEQ_MASK = 7'h7F;
  localparam logic [7:0] CMD_PING = 8'h81;
  localparam logic [7:0] CMD_INIT = 8'h86;
  localparam logic [7:0] CMD_WINK = 8'h88;
  localparam logic [7:0] CMD_CBOR = 8'h90;

  // Error codes
  localparam logic ERR_BAD_CMD = 1'b0;
  localparam logic ERR_BAD_SEQ = 1'b1;

  // Event queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Decoder mode within a report
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_HEADER = 3'd1,
    MODE_NONCE  = 3'd2,
    MODE_PING   = 3'd3,
    MODE_STREAM = 3'd4
  } mode_t;

  // Event kinds on the result channel
  typedef enum logic [2:0] {
    EV_MSG   = 3'd0,
    EV_ERROR = 3'd1,
    EV_INIT  = 3'd2,
    EV_PING  = 3'd3,
    EV_WINK  = 3'd4
  } kind_t;

  // One result beat
  typedef struct packed {
    kind_t        kind;
    logic [31:0]  channel_id;
    logic [7:0]   payload_byte;
    logic         has_data;
    logic         last_of_message;
    logic         error_code;
    logic [63:0]  init_nonce;
    logic [15:0]  message_length;
  } evt_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

endpackage
`default_nettype wire

// ----- rtl/ctaphid_report_deframer_core.sv -----
// CTAPHID report deframer: takes report bytes, produces header events and payload bytes.
//
// Input channel: one report byte per beat (in_data_byte), with in_report_start
// marking byte 0 of a report. Reports are REPORT_BYTES long; bytes outside a
// report are dropped. Each byte gives at most one result beat.
// Result channel: event kind, channel ID, payload byte with has_data and
// last_of_message, error code, init nonce and declared length.
// Throughput: one byte per cycle, sustained while in_ready is high; the decoder
// settles each byte in the cycle it is taken. A result is written into a two-entry
// event queue when its byte is taken, moves to the output register once that is
// free and shows on out_valid from then on, until the receiver takes it.
// When the receiver stalls, the output register holds its beat and the queue
// absorbs two more events; in_ready then drops until a result leaves.
// Reset (rst_n low, synchronous) clears the decoder to idle with no message
// active and empties the queue and output register.
`default_nettype none
module ctaphid_report_deframer_core #(
  parameter int REPORT_BYTES = ctd_pkg::REPORT_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_report_start,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        out_event_kind,
  output logic [31:0]       out_channel_id,
  output logic [7:0]        out_payload_byte,
  output logic              out_has_data,
  output logic              out_last_of_message,
  output logic              out_error_code,
  output logic [63:0]       out_init_nonce,
  output logic [15:0]       out_message_length
);

  logic             beat;
  logic             push;
  logic             pop;
  ctd_pkg::evt_t    front_evt;
  ctd_pkg::evt_t    head_evt;
  ctd_pkg::evt_t    out_evt;
  ctd_pkg::qstat_t  qstat;

  assign in_ready = !qstat.full;
  assign beat     = in_valid && in_ready;

  // Decoder
  ctd_front #(
    .REPORT_BYTES (REPORT_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat         (beat),
    .data_byte    (in_data_byte),
    .report_start (in_report_start),
    .push         (push),
    .evt          (front_evt)
  );

  // Event queue
  ctd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (front_evt),
    .pop      (pop),
    .stat     (qstat),
    .head_evt (head_evt)
  );

  // Output stage
  ctd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head_evt  (head_evt),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_evt   (out_evt)
  );

  // Result fields
  assign out_event_kind      = out_evt.kind;
  assign out_channel_id      = out_evt.channel_id;
  assign out_payload_byte    = out_evt.payload_byte;
  assign out_has_data        = out_evt.has_data;
  assign out_last_of_message = out_evt.last_of_message;
  assign out_error_code      = out_evt.error_code;
  assign out_init_nonce      = out_evt.init_nonce;
  assign out_message_length  = out_evt.message_length;

endmodule
`default_nettype wire

// ----- rtl/ctd_front.sv -----
// Front end: header decode and reassembly state, one report byte per beat.
`default_nettype none
module ctd_front #(
  parameter int REPORT_BYTES = ctd_pkg::REPORT_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          beat,
  input  wire logic [7:0]    data_byte,
  input  wire logic          report_start,
  output logic               push,
  output ctd_pkg::evt_t      evt
);

  localparam int POS_W = $clog2(REPORT_BYTES);

  // State registers
  ctd_pkg::mode_t    mode_r, mode_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [31:0]       hdr_chan_r, hdr_chan_nxt;
  logic [7:0]        hdr_cmd_r, hdr_cmd_nxt;
  logic [15:0]       hdr_len_r, hdr_len_nxt;
  logic [63:0]       nonce_r, nonce_nxt;
  logic [31:0]       msg_chan_r, msg_chan_nxt;
  logic [15:0]       msg_total_r, msg_total_nxt;
  logic [15:0]       msg_rcv_r, msg_rcv_nxt;
  logic [6:0]        exp_seq_r, exp_seq_nxt;
  logic              msg_active_r, msg_active_nxt;

  // Shared decode terms
  ctd_pkg::mode_t    mode_cur;
  logic [POS_W-1:0]  pos_cur;
  logic [31:0]       chan_shift;
  logic [15:0]       len_full;
  logic [63:0]       nonce_shift;
  logic [15:0]       rcv_inc;
  logic              cont_match;
  logic              seq_ok;
  logic              known_cmd;
  logic              stream_last;
  logic              ping_last;
  logic              pos_end;

  always_comb begin
    mode_cur    = report_start ? ctd_pkg::MODE_HEADER : mode_r;
    pos_cur     = report_start ? '0 : pos_r;
    chan_shift  = {hdr_chan_r[23:0], data_byte};
    len_full    = {hdr_len_r[15:8], data_byte};
    nonce_shift = {nonce_r[55:0], data_byte};
    rcv_inc     = msg_rcv_r + 16'd1;
    cont_match  = msg_active_r && (hdr_chan_r == msg_chan_r);
    seq_ok      = (data_byte[6:0] & ctd_pkg::SEQ_MASK) == exp_seq_r;
    known_cmd   = (data_byte == ctd_pkg::CMD_INIT) || (data_byte == ctd_pkg::CMD_PING) ||
                  (data_byte == ctd_pkg::CMD_CBOR);
    stream_last = rcv_inc >= msg_total_r;
    ping_last   = ((16'(pos_cur) - 16'(ctd_pkg::LEN_LO_POS)) == hdr_len_r) ||
                  (pos_cur == POS_W'(REPORT_BYTES - 1));
    pos_end     = pos_cur == POS_W'(REPORT_BYTES - 1);
  end

  // Next state
  always_comb begin
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    hdr_chan_nxt   = hdr_chan_r;
    hdr_cmd_nxt    = hdr_cmd_r;
    hdr_len_nxt    = hdr_len_r;
    nonce_nxt      = nonce_r;
    msg_chan_nxt   = msg_chan_r;
    msg_total_nxt  = msg_total_r;
    msg_rcv_nxt    = msg_rcv_r;
    exp_seq_nxt    = exp_seq_r;
    msg_active_nxt = msg_active_r;
    if (beat && (mode_cur != ctd_pkg::MODE_IDLE)) begin
      mode_nxt = mode_cur;
      pos_nxt  = pos_end ? pos_cur : pos_cur + POS_W'(1);
      case (mode_cur)
        ctd_pkg::MODE_HEADER: begin
          if (pos_cur <= POS_W'(ctd_pkg::CHAN_LAST_POS)) begin
            hdr_chan_nxt = chan_shift;
          end else if (pos_cur == POS_W'(ctd_pkg::CMD_POS)) begin
            if ((data_byte & ctd_pkg::CMD_FLAG) != 8'h00) begin
              hdr_cmd_nxt = data_byte;
              if (!known_cmd) begin
                mode_nxt = ctd_pkg::MODE_IDLE;
              end
            end else if (cont_match) begin
              if (!seq_ok) begin
                msg_active_nxt = 1'b0;
                mode_nxt       = ctd_pkg::MODE_IDLE;
              end else begin
                exp_seq_nxt = exp_seq_r + 7'd1;
                mode_nxt    = ctd_pkg::MODE_STREAM;
              end
            end else begin
              mode_nxt = ctd_pkg::MODE_IDLE;
            end
          end else if (pos_cur == POS_W'(ctd_pkg::LEN_HI_POS)) begin
            hdr_len_nxt = {data_byte, 8'h00};
          end else begin
            hdr_len_nxt = len_full;
            case (hdr_cmd_r)
              ctd_pkg::CMD_INIT: begin
                mode_nxt = ctd_pkg::MODE_NONCE;
              end
              ctd_pkg::CMD_PING: begin
                mode_nxt = (len_full == 16'd0) ? ctd_pkg::MODE_IDLE : ctd_pkg::MODE_PING;
              end
              default: begin
                msg_chan_nxt   = hdr_chan_r;
                msg_total_nxt  = len_full;
                msg_rcv_nxt    = 16'd0;
                exp_seq_nxt    = 7'd0;
                msg_active_nxt = len_full != 16'd0;
                mode_nxt = (len_full == 16'd0) ? ctd_pkg::MODE_IDLE : ctd_pkg::MODE_STREAM;
              end
            endcase
          end
        end
        ctd_pkg::MODE_NONCE: begin
          nonce_nxt = nonce_shift;
          if (pos_cur == POS_W'(ctd_pkg::NONCE_LAST_POS)) begin
            mode_nxt = ctd_pkg::MODE_IDLE;
          end
        end
        ctd_pkg::MODE_PING: begin
          if (ping_last) begin
            mode_nxt = ctd_pkg::MODE_IDLE;
          end
        end
        ctd_pkg::MODE_STREAM: begin
          msg_rcv_nxt = rcv_inc;
          if (stream_last) begin
            msg_active_nxt = 1'b0;
            mode_nxt       = ctd_pkg::MODE_IDLE;
          end
        end
        default: begin
          mode_nxt = ctd_pkg::MODE_IDLE;
        end
      endcase
      // Report ends after its last byte
      if (pos_end) begin
        mode_nxt = ctd_pkg::MODE_IDLE;
      end
    end
  end

  // Event generation
  always_comb begin
    push = 1'b0;
    evt  = '0;
    if (beat) begin
      case (mode_cur)
        ctd_pkg::MODE_HEADER: begin
          if (pos_cur == POS_W'(ctd_pkg::CMD_POS)) begin
            if ((data_byte & ctd_pkg::CMD_FLAG) != 8'h00) begin
              if (data_byte == ctd_pkg::CMD_WINK) begin
                push           = 1'b1;
                evt.kind       = ctd_pkg::EV_WINK;
                evt.channel_id = hdr_chan_r;
              end else if (!known_cmd) begin
                push           = 1'b1;
                evt.kind       = ctd_pkg::EV_ERROR;
                evt.channel_id = hdr_chan_r;
                evt.error_code = ctd_pkg::ERR_BAD_CMD;
              end
            end else if (cont_match && !seq_ok) begin
              push           = 1'b1;
              evt.kind       = ctd_pkg::EV_ERROR;
              evt.channel_id = hdr_chan_r;
              evt.error_code = ctd_pkg::ERR_BAD_SEQ;
            end
          end else if ((pos_cur > POS_W'(ctd_pkg::LEN_HI_POS)) && (len_full == 16'd0) &&
                       (hdr_cmd_r != ctd_pkg::CMD_INIT)) begin
            // Empty ping or empty message
            push                = 1'b1;
            evt.kind            = (hdr_cmd_r == ctd_pkg::CMD_PING) ? ctd_pkg::EV_PING
                                                                   : ctd_pkg::EV_MSG;
            evt.channel_id      = hdr_chan_r;
            evt.last_of_message = 1'b1;
          end
        end
        ctd_pkg::MODE_NONCE: begin
          if (pos_cur == POS_W'(ctd_pkg::NONCE_LAST_POS)) begin
            push               = 1'b1;
            evt.kind           = ctd_pkg::EV_INIT;
            evt.channel_id     = hdr_chan_r;
            evt.init_nonce     = nonce_shift;
            evt.message_length = hdr_len_r;
          end
        end
        ctd_pkg::MODE_PING: begin
          push                = 1'b1;
          evt.kind            = ctd_pkg::EV_PING;
          evt.channel_id      = hdr_chan_r;
          evt.payload_byte    = data_byte;
          evt.has_data        = 1'b1;
          evt.last_of_message = ping_last;
          evt.message_length  = hdr_len_r;
        end
        ctd_pkg::MODE_STREAM: begin
          push                = 1'b1;
          evt.kind            = ctd_pkg::EV_MSG;
          evt.channel_id      = msg_chan_r;
          evt.payload_byte    = data_byte;
          evt.has_data        = 1'b1;
          evt.last_of_message = stream_last;
          evt.message_length  = msg_total_r;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= ctd_pkg::MODE_IDLE;
      pos_r        <= '0;
      hdr_chan_r   <= '0;
      hdr_cmd_r    <= '0;
      hdr_len_r    <= '0;
      nonce_r      <= '0;
      msg_chan_r   <= '0;
      msg_total_r  <= '0;
      msg_rcv_r    <= '0;
      exp_seq_r    <= '0;
      msg_active_r <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      pos_r        <= pos_nxt;
      hdr_chan_r   <= hdr_chan_nxt;
      hdr_cmd_r    <= hdr_cmd_nxt;
      hdr_len_r    <= hdr_len_nxt;
      nonce_r      <= nonce_nxt;
      msg_chan_r   <= msg_chan_nxt;
      msg_total_r  <= msg_total_nxt;
      msg_rcv_r    <= msg_rcv_nxt;
      exp_seq_r    <= exp_seq_nxt;
      msg_active_r <= msg_active_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ctd_queue.sv -----
// Short event queue between the decoder front end and the output stage.
`default_nettype none
module ctd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ctd_pkg::evt_t   push_evt,
  input  wire logic            pop,
  output ctd_pkg::qstat_t      stat,
  output ctd_pkg::evt_t        head_evt
);

  localparam int DEPTH  = ctd_pkg::QUEUE_DEPTH;
  localparam int PTR_W  = ctd_pkg::QPTR_W;
  localparam int CNT_W  = ctd_pkg::QCNT_W;

  ctd_pkg::evt_t      slot_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // Pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    stat.full  = cnt_r == CNT_W'(DEPTH);
    stat.valid = cnt_r != '0;
    head_evt   = slot_r[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_evt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ctd_back.sv -----
// Back end: output register that presents queued events on the result channel.
`default_nettype none
module ctd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctd_pkg::qstat_t  qstat,
  input  wire ctd_pkg::evt_t    head_evt,
  output logic                  pop,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output ctd_pkg::evt_t         out_evt
);

  logic           valid_r, valid_nxt;
  ctd_pkg::evt_t  evt_r;

  // Load when empty or when the current beat leaves
  always_comb begin
    pop       = qstat.valid && (!valid_r || out_ready);
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      evt_r <= head_evt;
    end
  end

  assign out_valid = valid_r;
  assign out_evt   = evt_r;

endmodule
`default_nettype wire
